// ===== rtl/cale_pkg.sv =====
// shared types and constants of the cursor array list engine
package cale_pkg;

    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_DATA_WIDTH = 32;

    localparam int ITEM_W   = 32;
    localparam int POS_W    = 6;
    localparam int VALUE_W  = 32;
    localparam int MATCH_W  = 6;
    localparam int LENGTH_W = 7;
    localparam int CURSOR_W = 6;

    typedef enum logic [3:0] {
        FN_APPEND = 4'd0,
        FN_INSERT = 4'd1,
        FN_ERASE  = 4'd2,
        FN_FIND   = 4'd3,
        FN_BEGIN  = 4'd4,
        FN_END    = 4'd5,
        FN_PREV   = 4'd6,
        FN_NEXT   = 4'd7,
        FN_SETPOS = 4'd8,
        FN_READ   = 4'd9,
        FN_CLEAR  = 4'd10
    } func_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_IGNORED = 2'd3
    } status_t;

    typedef struct packed {
        logic [CURSOR_W-1:0] cursor_now;
        logic [LENGTH_W-1:0] list_length;
        status_t             status;
        logic [MATCH_W-1:0]  match_index;
        logic                found;
        logic [VALUE_W-1:0]  value;
    } result_t;

endpackage

// ===== rtl/cale_ctrl.sv =====
// list sequencer: entry store, walk counter with compare, cursor and length
module cale_ctrl #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  cale_pkg::func_t                     s_func,
    input  logic [cale_pkg::ITEM_W-1:0]         s_item,
    input  logic [cale_pkg::POS_W-1:0]          s_position,
    output logic                                res_valid,
    input  logic                                res_ready,
    output cale_pkg::result_t                   res
);
    import cale_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int PW = (LW > POS_W) ? LW : POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INS_PUT,
        S_ERS_HEAD,
        S_ERS,
        S_FIND,
        S_READ,
        S_DONE
    } state_t;

    state_t                state_reg;
    logic [LW-1:0]         length_reg;
    logic [AW-1:0]         cursor_reg;
    logic [AW-1:0]         walk_reg;
    logic [DATA_WIDTH-1:0] item_reg;
    logic [VALUE_W-1:0]    value_reg;
    logic                  found_reg;
    logic [MATCH_W-1:0]    match_reg;
    status_t               status_reg;

    logic [DATA_WIDTH-1:0] mem [CAPACITY];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    logic                  accept;
    logic [DATA_WIDTH-1:0] item_in;
    logic                  full;
    logic                  empty;
    logic                  at_end;
    logic                  cursor_last;
    logic                  next_ok;
    logic                  pos_ok;
    logic                  walk_last;
    logic                  hit;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;

    assign accept      = s_valid && (state_reg == S_IDLE);
    assign s_ready     = (state_reg == S_IDLE);
    assign item_in     = DATA_WIDTH'(s_item);
    assign full        = (length_reg == LW'(CAPACITY));
    assign empty       = (length_reg == '0);
    assign at_end      = (LW'(cursor_reg) == length_reg);
    assign cursor_last = (LW'(LW'(cursor_reg) + LW'(1)) == length_reg);
    assign next_ok     = (LW'(LW'(cursor_reg) + LW'(1)) < length_reg);
    assign pos_ok      = (PW'(s_position) < PW'(length_reg));
    assign walk_last   = (LW'(LW'(walk_reg) + LW'(1)) == length_reg);
    assign hit         = (rd_data_reg == item_reg);

    // memory port control
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = cursor_reg;
        wr_data = rd_data_reg;
        rd_en   = 1'b0;
        rd_addr = walk_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (s_func)
                        FN_APPEND: begin
                            if (!full) begin
                                wr_en   = 1'b1;
                                wr_addr = AW'(length_reg);
                                wr_data = item_in;
                            end
                        end
                        FN_INSERT: begin
                            if (!full) begin
                                if (at_end) begin
                                    wr_en   = 1'b1;
                                    wr_addr = cursor_reg;
                                    wr_data = item_in;
                                end else begin
                                    rd_en   = 1'b1;
                                    rd_addr = AW'(length_reg - LW'(1));
                                end
                            end
                        end
                        FN_ERASE, FN_READ: begin
                            if (!empty) begin
                                rd_en   = 1'b1;
                                rd_addr = cursor_reg;
                            end
                        end
                        FN_FIND: begin
                            if (!empty) begin
                                rd_en   = 1'b1;
                                rd_addr = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_INS: begin
                wr_en   = 1'b1;
                wr_addr = walk_reg + AW'(1);
                wr_data = rd_data_reg;
                if (walk_reg != cursor_reg) begin
                    rd_en   = 1'b1;
                    rd_addr = walk_reg - AW'(1);
                end
            end
            S_INS_PUT: begin
                wr_en   = 1'b1;
                wr_addr = cursor_reg;
                wr_data = item_reg;
            end
            S_ERS_HEAD: begin
                if (!cursor_last) begin
                    rd_en   = 1'b1;
                    rd_addr = cursor_reg + AW'(1);
                end
            end
            S_ERS: begin
                wr_en   = 1'b1;
                wr_addr = walk_reg - AW'(1);
                wr_data = rd_data_reg;
                if (!walk_last) begin
                    rd_en   = 1'b1;
                    rd_addr = walk_reg + AW'(1);
                end
            end
            S_FIND: begin
                if (!hit && !walk_last) begin
                    rd_en   = 1'b1;
                    rd_addr = walk_reg + AW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            length_reg <= '0;
            cursor_reg <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        value_reg  <= '0;
                        found_reg  <= 1'b0;
                        match_reg  <= '0;
                        status_reg <= ST_OK;
                        item_reg   <= item_in;
                        state_reg  <= S_DONE;
                        unique case (s_func)
                            FN_APPEND: begin
                                if (full) begin
                                    status_reg <= ST_FULL;
                                end else begin
                                    length_reg <= length_reg + LW'(1);
                                end
                            end
                            FN_INSERT: begin
                                if (full) begin
                                    status_reg <= ST_FULL;
                                end else if (at_end) begin
                                    length_reg <= length_reg + LW'(1);
                                end else begin
                                    walk_reg  <= AW'(length_reg - LW'(1));
                                    state_reg <= S_INS;
                                end
                            end
                            FN_ERASE: begin
                                if (empty) begin
                                    status_reg <= ST_EMPTY;
                                end else begin
                                    state_reg <= S_ERS_HEAD;
                                end
                            end
                            FN_FIND: begin
                                if (empty) begin
                                    status_reg <= ST_EMPTY;
                                end else begin
                                    walk_reg  <= '0;
                                    state_reg <= S_FIND;
                                end
                            end
                            FN_BEGIN: begin
                                cursor_reg <= '0;
                            end
                            FN_END: begin
                                cursor_reg <= empty ? '0 : AW'(length_reg - LW'(1));
                            end
                            FN_PREV: begin
                                if (cursor_reg != '0) begin
                                    cursor_reg <= cursor_reg - AW'(1);
                                end
                            end
                            FN_NEXT: begin
                                if (next_ok) begin
                                    cursor_reg <= cursor_reg + AW'(1);
                                end
                            end
                            FN_SETPOS: begin
                                if (pos_ok) begin
                                    cursor_reg <= AW'(s_position);
                                end else begin
                                    status_reg <= ST_IGNORED;
                                end
                            end
                            FN_READ: begin
                                if (empty) begin
                                    status_reg <= ST_EMPTY;
                                end else begin
                                    state_reg <= S_READ;
                                end
                            end
                            FN_CLEAR: begin
                                length_reg <= '0;
                                cursor_reg <= '0;
                            end
                            default: begin
                                status_reg <= ST_IGNORED;
                            end
                        endcase
                    end
                end
                S_INS: begin
                    if (walk_reg == cursor_reg) begin
                        state_reg <= S_INS_PUT;
                    end else begin
                        walk_reg <= walk_reg - AW'(1);
                    end
                end
                S_INS_PUT: begin
                    length_reg <= length_reg + LW'(1);
                    state_reg  <= S_DONE;
                end
                S_ERS_HEAD: begin
                    value_reg <= VALUE_W'(rd_data_reg);
                    if (cursor_last) begin
                        if (length_reg != LW'(1)) begin
                            cursor_reg <= cursor_reg - AW'(1);
                        end
                        length_reg <= length_reg - LW'(1);
                        state_reg  <= S_DONE;
                    end else begin
                        walk_reg  <= cursor_reg + AW'(1);
                        state_reg <= S_ERS;
                    end
                end
                S_ERS: begin
                    if (walk_last) begin
                        length_reg <= length_reg - LW'(1);
                        state_reg  <= S_DONE;
                    end else begin
                        walk_reg <= walk_reg + AW'(1);
                    end
                end
                S_FIND: begin
                    if (hit) begin
                        found_reg <= 1'b1;
                        match_reg <= MATCH_W'(walk_reg);
                        state_reg <= S_DONE;
                    end else if (walk_last) begin
                        state_reg <= S_DONE;
                    end else begin
                        walk_reg <= walk_reg + AW'(1);
                    end
                end
                S_READ: begin
                    value_reg <= VALUE_W'(rd_data_reg);
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (res_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res_valid = (state_reg == S_DONE);

    always_comb begin
        res.value       = value_reg;
        res.found       = found_reg;
        res.match_index = match_reg;
        res.status      = status_reg;
        res.list_length = LENGTH_W'(length_reg);
        res.cursor_now  = CURSOR_W'(cursor_reg);
    end

    a_length_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        length_reg <= LW'(CAPACITY))
        else $error("list length above capacity");

    a_cursor_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (length_reg == '0) |-> (cursor_reg == '0))
        else $error("cursor off zero on empty list");

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (length_reg != '0) |-> (LW'(cursor_reg) < length_reg))
        else $error("cursor beyond list end");

    a_ins_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_INS) |-> (walk_reg >= cursor_reg))
        else $error("insert walk passed the cursor");

    a_scan_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIND || state_reg == S_ERS) |-> (LW'(walk_reg) < length_reg))
        else $error("scan walk beyond list end");

endmodule

// ===== rtl/cursor_array_list_engine_top.sv =====
// simple cursor and append requests go from accept to S_DONE and then to the output register
// insert shifts entries up to open the cursor slot, erase shifts later entries down, find scans from 0
// one request at a time: the entry store walk, one entry per cycle, sets the rate
// a result waits in the output register while the next request is taken
// reset clears length and cursor at once; the entry store is not cleared
module cursor_array_list_engine_top #(
    parameter int CAPACITY   = cale_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = cale_pkg::DEF_DATA_WIDTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // item[31:0], position[37:32], zero[39:38]
    input  logic [3:0]  s_tuser,   // func[3:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // value[31:0], found[32], match_index[38:33],
                                   // status[40:39], list_length[47:41],
                                   // cursor_now[53:48], zero[55:54]
);
    import cale_pkg::*;

    logic    res_valid;
    logic    res_ready;
    result_t res;
    logic    out_valid_reg;
    result_t out_reg;

    cale_ctrl #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_func     (func_t'(s_tuser)),
        .s_item     (s_tdata[31:0]),
        .s_position (s_tdata[37:32]),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            if (res_ready) begin
                out_valid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.cursor_now, out_reg.list_length, out_reg.status,
                       out_reg.match_index, out_reg.found, out_reg.value};

endmodule
